/* hdl/u7e_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-7 encoder package
// Shared types, character constants and helper functions for the UTF-16 to
// UTF-7 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u7e_pkg;

  localparam int unsigned MaxBytes = 6;
  localparam int unsigned NumW     = 3;

  localparam logic [7:0]  CharPlus  = 8'h2B;
  localparam logic [7:0]  CharMinus = 8'h2D;
  localparam logic [15:0] UnitPlus  = 16'h002B;
  localparam logic [7:0]  LowMask   = 8'hFF;

  localparam logic [2:0] CntZero = 3'd0;
  localparam logic [2:0] CntTwo  = 3'd2;
  localparam logic [2:0] CntFour = 3'd4;

  typedef struct packed {
    logic       in_run;
    logic [3:0] bits;
    logic [2:0] count;
  } run_st_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [NumW-1:0]          num;
    run_st_t                  st;
  } enc_res_t;

  function automatic logic is_direct(logic [15:0] u);
    logic res;
    res = 1'b0;
    if (u inside {[16'h0041:16'h005A], [16'h0061:16'h007A], [16'h0030:16'h0039],
                  16'h0027, 16'h0028, 16'h0029, 16'h002C, 16'h002D, 16'h002E,
                  16'h002F, 16'h003A, 16'h003F, 16'h0020, 16'h0009, 16'h000D,
                  16'h000A}) begin
      res = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [7:0] b64_char(logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = {2'b00, v} + 8'd65;
    end else if (v < 6'd52) begin
      c = {2'b00, v} + 8'd71;
    end else if (v < 6'd62) begin
      c = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hdl/u7e_pack.sv */
// ----------------------------------------------------------------------------
// UTF-7 unit packer
// Turns one UTF-16 code unit and the current run state into the list of
// UTF-7 bytes it produces and the run state that follows.
// ----------------------------------------------------------------------------
`default_nettype none

module u7e_pack (
  input  wire logic [15:0]       unit_i,
  input  wire logic              fin_i,
  input  wire u7e_pkg::run_st_t  st_i,
  output u7e_pkg::enc_res_t      res_o
);

  always_comb begin
    logic [u7e_pkg::MaxBytes-1:0][7:0] bytes;
    logic [u7e_pkg::NumW-1:0]          pos;
    u7e_pkg::run_st_t                  st;
    logic [19:0]                       acc;

    bytes = '0;
    pos   = '0;
    st    = st_i;
    acc   = {(st_i.in_run ? st_i.bits : 4'd0), unit_i};

    if (u7e_pkg::is_direct(unit_i)) begin
      if (st.in_run) begin
        if (st.count == u7e_pkg::CntTwo) begin
          bytes[pos] = u7e_pkg::b64_char({st.bits[1:0], 4'b0000});
          pos = pos + 3'd1;
        end else if (st.count == u7e_pkg::CntFour) begin
          bytes[pos] = u7e_pkg::b64_char({st.bits, 2'b00});
          pos = pos + 3'd1;
        end
        bytes[pos] = u7e_pkg::CharMinus;
        pos = pos + 3'd1;
        st = '0;
      end
      bytes[pos] = unit_i[7:0] & u7e_pkg::LowMask;
      pos = pos + 3'd1;
    end else if (unit_i == u7e_pkg::UnitPlus && !st.in_run) begin
      bytes[0] = u7e_pkg::CharPlus;
      bytes[1] = u7e_pkg::CharMinus;
      pos = 3'd2;
    end else begin
      if (!st.in_run) begin
        bytes[pos] = u7e_pkg::CharPlus;
        pos = pos + 3'd1;
        st = '{in_run: 1'b1, bits: 4'd0, count: u7e_pkg::CntZero};
      end
      case (st.count)
        u7e_pkg::CntTwo: begin
          bytes[pos] = u7e_pkg::b64_char(acc[17:12]);
          pos = pos + 3'd1;
          bytes[pos] = u7e_pkg::b64_char(acc[11:6]);
          pos = pos + 3'd1;
          bytes[pos] = u7e_pkg::b64_char(acc[5:0]);
          pos = pos + 3'd1;
          st.bits  = 4'd0;
          st.count = u7e_pkg::CntZero;
        end
        u7e_pkg::CntFour: begin
          bytes[pos] = u7e_pkg::b64_char(acc[19:14]);
          pos = pos + 3'd1;
          bytes[pos] = u7e_pkg::b64_char(acc[13:8]);
          pos = pos + 3'd1;
          bytes[pos] = u7e_pkg::b64_char(acc[7:2]);
          pos = pos + 3'd1;
          st.bits  = {2'b00, acc[1:0]};
          st.count = u7e_pkg::CntTwo;
        end
        default: begin
          bytes[pos] = u7e_pkg::b64_char(acc[15:10]);
          pos = pos + 3'd1;
          bytes[pos] = u7e_pkg::b64_char(acc[9:4]);
          pos = pos + 3'd1;
          st.bits  = acc[3:0];
          st.count = u7e_pkg::CntFour;
        end
      endcase
    end

    if (fin_i && st.in_run) begin
      if (st.count == u7e_pkg::CntTwo) begin
        bytes[pos] = u7e_pkg::b64_char({st.bits[1:0], 4'b0000});
        pos = pos + 3'd1;
      end else if (st.count == u7e_pkg::CntFour) begin
        bytes[pos] = u7e_pkg::b64_char({st.bits, 2'b00});
        pos = pos + 3'd1;
      end
      bytes[pos] = u7e_pkg::CharMinus;
      pos = pos + 3'd1;
      st = '0;
    end

    res_o.bytes = bytes;
    res_o.num   = pos;
    res_o.st    = st;
  end

endmodule

`default_nettype wire

/* hdl/utf16_to_utf7_encoder_core.sv */
// ----------------------------------------------------------------------------
// UTF-16 to UTF-7 encoder core
// Encodes a stream of UTF-16 code units into UTF-7 bytes, one byte per
// output transaction.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o  code_unit_i, final_unit_i
//   out      output     out_valid_o/out_ready_i out_byte_o, last_of_run_o
//
// A unit is encoded in one pass from the input register into a byte buffer.
// The buffer then sends one byte per cycle while out_ready_i is high, so a unit
// gives 1 to 5 output bytes; the single output byte lane sets the rate.
// A new unit is taken while the buffer drains; the input register holds it.
// Reset clears the run state and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_to_utf7_encoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [15:0] code_unit_i,
  input  wire logic        final_unit_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [7:0]  out_byte_o,
  output      logic        last_of_run_o
);

  logic                               in_valid_q, in_valid_d;
  logic [15:0]                        unit_q;
  logic                               fin_q;
  logic                               buf_valid_q, buf_valid_d;
  logic [u7e_pkg::MaxBytes-1:0][7:0]  bytes_q;
  logic [u7e_pkg::NumW-1:0]           num_q;
  logic [u7e_pkg::NumW-1:0]           idx_q, idx_d;
  u7e_pkg::run_st_t                   st_q, st_d;
  u7e_pkg::enc_res_t                  enc;
  logic                               last, out_take, buf_free, load, in_take;

  u7e_pack u_pack (
    .unit_i (unit_q),
    .fin_i  (fin_q),
    .st_i   (st_q),
    .res_o  (enc)
  );

  assign last       = (idx_q == (num_q - 3'd1));
  assign out_take   = buf_valid_q && out_ready_i;
  assign buf_free   = !buf_valid_q || (out_take && last);
  assign load       = in_valid_q && buf_free;
  assign in_ready_o = !in_valid_q || load;
  assign in_take    = in_valid_i && in_ready_o;

  assign out_valid_o   = buf_valid_q;
  assign out_byte_o    = bytes_q[idx_q];
  assign last_of_run_o = last;

  always_comb begin
    in_valid_d  = in_valid_q;
    buf_valid_d = buf_valid_q;
    idx_d       = idx_q;
    st_d        = st_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
    if (load) begin
      buf_valid_d = 1'b1;
      idx_d       = '0;
      st_d        = enc.st;
    end else if (out_take) begin
      if (last) begin
        buf_valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      buf_valid_q <= 1'b0;
      idx_q       <= '0;
      st_q        <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      buf_valid_q <= buf_valid_d;
      idx_q       <= idx_d;
      st_q        <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      unit_q <= code_unit_i;
      fin_q  <= final_unit_i;
    end
    if (load) begin
      bytes_q <= enc.bytes;
      num_q   <= enc.num;
    end
  end

endmodule

`default_nettype wire

/* hdl/u7e_checker.sv */
// ----------------------------------------------------------------------------
// UTF-7 encoder port checker
// Watches the ports of the encoder core and flags illegal output sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module u7e_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  out_byte_o,
  input wire logic        last_of_run_o
);

  logic is_b64;

  assign is_b64 = (out_byte_o >= 8'h41 && out_byte_o <= 8'h5A) ||
                  (out_byte_o >= 8'h61 && out_byte_o <= 8'h7A) ||
                  (out_byte_o >= 8'h30 && out_byte_o <= 8'h39) ||
                  out_byte_o == u7e_pkg::CharPlus || out_byte_o == 8'h2F;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(last_of_run_o))
    else $error("Output transaction changed while stalled.");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=> out_valid_o)
    else $error("Bytes of one unit were not sent back to back.");

  a_inner_alphabet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> is_b64 || out_byte_o == u7e_pkg::CharMinus)
    else $error("Inner byte of a unit is outside the shifted alphabet.");

  a_known_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown({out_byte_o, last_of_run_o}))
    else $error("Output transaction carries unknown bits.");

endmodule

bind utf16_to_utf7_encoder_core u7e_checker u_u7e_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_byte_o    (out_byte_o),
  .last_of_run_o (last_of_run_o)
);

`default_nettype wire
